@@ hw/rtl/pwwd_pkg.sv @@
package pwwd_pkg;

  // Widths of the item and result fields
  localparam int DUR_W      = 16;
  localparam int DATA_W     = 32;
  localparam int PRE_CNT_W  = 8;
  localparam int BIT_CNT_W  = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 24;   // 17 payload bits padded to bytes
  localparam int OUT_TDATA_W = 40;   // 33 payload bits padded to bytes

  localparam int PACKET_BITS_DEF = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_THRESHOLD = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PREAMBLE   = 1'd1;

  localparam logic [DUR_W-1:0]     LONG_THRESHOLD_RST = 16'd2000;
  localparam logic [PRE_CNT_W-1:0] MIN_PREAMBLE_RST   = 8'd10;

  // Pulse windows in microseconds, bounds inclusive
  localparam logic [DUR_W-1:0] PRE_HI_MIN    = 16'd1400;
  localparam logic [DUR_W-1:0] PRE_HI_MAX    = 16'd2000;
  localparam logic [DUR_W-1:0] PRE_LO_MIN    = 16'd1000;
  localparam logic [DUR_W-1:0] PRE_LO_MAX    = 16'd1600;
  localparam logic [DUR_W-1:0] SYNC_LO_MIN   = 16'd4000;
  localparam logic [DUR_W-1:0] SYNC_LO_MAX   = 16'd4600;
  localparam logic [DUR_W-1:0] SYNC_HI_MIN   = 16'd5300;
  localparam logic [DUR_W-1:0] SYNC_HI_MAX   = 16'd6000;
  localparam logic [DUR_W-1:0] FIN_SHORT_MIN = 16'd5000;
  localparam logic [DUR_W-1:0] FIN_SHORT_MAX = 16'd6000;
  localparam logic [DUR_W-1:0] FIN_LONG_MAX  = 16'd7500;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PREAMBLE  = 3'd1,
    PH_SYNC_LOW  = 3'd2,
    PH_SYNC_HIGH = 3'd3,
    PH_WAIT      = 3'd4,
    PH_ONE       = 3'd5,
    PH_ZERO      = 3'd6
  } phase_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             pin_level;
  } pulse_t;

  typedef struct packed {
    logic              packet_valid;
    logic [DATA_W-1:0] packet_data;
  } result_t;

  typedef struct packed {
    logic [DUR_W-1:0]     long_threshold;
    logic [PRE_CNT_W-1:0] min_preamble;
  } cfg_t;

endpackage

@@ hw/rtl/pwwd_in_stage.sv @@
module pwwd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  pwwd_pkg::pulse_t in_pulse,
  input  logic            adv,
  output logic            valid,
  output pwwd_pkg::pulse_t pulse
);

  logic             valid_r, valid_nxt;
  pwwd_pkg::pulse_t pulse_r;

  // Slot is free when empty or when its pulse moves on this cycle
  assign in_tready = !valid_r || adv;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pulse_r <= in_pulse;
    end
  end

  assign valid = valid_r;
  assign pulse = pulse_r;

endmodule

@@ hw/rtl/pwwd_fsm.sv @@
module pwwd_fsm #(
  parameter int PACKET_BITS = pwwd_pkg::PACKET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  pwwd_pkg::pulse_t  pulse,
  input  pwwd_pkg::cfg_t    cfg,
  output pwwd_pkg::result_t result
);

  localparam logic [pwwd_pkg::BIT_CNT_W-1:0] PKT_BITS_C =
    pwwd_pkg::BIT_CNT_W'(PACKET_BITS);

  pwwd_pkg::phase_t                     phase_r, phase_nxt;
  logic [pwwd_pkg::PRE_CNT_W-1:0]       pre_cnt_r, pre_cnt_nxt;
  logic [pwwd_pkg::DATA_W-1:0]          store_r, store_nxt;
  logic [pwwd_pkg::BIT_CNT_W-1:0]       cnt_r, cnt_nxt;

  logic [pwwd_pkg::DUR_W-1:0] dur;
  logic high, is_long, hi_pre, lo_pre, sync_lo, sync_hi, fin_short, fin_long;
  logic check;

  assign dur       = pulse.duration;
  assign high      = pulse.pin_level;
  assign is_long   = dur > cfg.long_threshold;
  assign hi_pre    = high && dur >= pwwd_pkg::PRE_HI_MIN && dur <= pwwd_pkg::PRE_HI_MAX;
  assign lo_pre    = !high && dur >= pwwd_pkg::PRE_LO_MIN && dur <= pwwd_pkg::PRE_LO_MAX;
  assign sync_lo   = !high && dur >= pwwd_pkg::SYNC_LO_MIN && dur <= pwwd_pkg::SYNC_LO_MAX;
  assign sync_hi   = high && dur >= pwwd_pkg::SYNC_HI_MIN && dur <= pwwd_pkg::SYNC_HI_MAX;
  assign fin_short = !high && dur >= pwwd_pkg::FIN_SHORT_MIN &&
                     dur <= pwwd_pkg::FIN_SHORT_MAX;
  assign fin_long  = !high && dur > pwwd_pkg::FIN_SHORT_MAX &&
                     dur <= pwwd_pkg::FIN_LONG_MAX;

  always_comb begin
    phase_nxt   = phase_r;
    pre_cnt_nxt = pre_cnt_r;
    store_nxt   = store_r;
    cnt_nxt     = cnt_r;
    check       = 1'b0;
    result      = '0;

    case (phase_r)
      pwwd_pkg::PH_IDLE: begin
        store_nxt   = '0;
        cnt_nxt     = '0;
        pre_cnt_nxt = '0;
        if (hi_pre) begin
          phase_nxt   = pwwd_pkg::PH_PREAMBLE;
          pre_cnt_nxt = 8'd1;
        end
      end
      pwwd_pkg::PH_PREAMBLE: begin
        if (lo_pre || hi_pre) begin
          if (pre_cnt_r != '1) pre_cnt_nxt = pre_cnt_r + 8'd1;
        end else if (sync_lo && pre_cnt_r > cfg.min_preamble) begin
          phase_nxt = pwwd_pkg::PH_SYNC_LOW;
        end else begin
          phase_nxt   = pwwd_pkg::PH_IDLE;
          pre_cnt_nxt = '0;
          store_nxt   = '0;
          cnt_nxt     = '0;
        end
      end
      pwwd_pkg::PH_SYNC_LOW: begin
        if (sync_hi) begin
          phase_nxt = pwwd_pkg::PH_SYNC_HIGH;
        end else begin
          phase_nxt   = pwwd_pkg::PH_IDLE;
          pre_cnt_nxt = '0;
          store_nxt   = '0;
          cnt_nxt     = '0;
        end
      end
      pwwd_pkg::PH_SYNC_HIGH: begin
        if (fin_short) begin
          phase_nxt = pwwd_pkg::PH_WAIT;
        end else if (fin_long) begin
          phase_nxt = pwwd_pkg::PH_ZERO;
        end else begin
          phase_nxt   = pwwd_pkg::PH_IDLE;
          pre_cnt_nxt = '0;
          store_nxt   = '0;
          cnt_nxt     = '0;
        end
      end
      pwwd_pkg::PH_ONE: begin
        // bits past the store width are counted only
        if (cnt_r < 7'd32) store_nxt = store_r | (32'd1 << cnt_r[4:0]);
        cnt_nxt   = cnt_r + 7'd1;
        phase_nxt = is_long ? pwwd_pkg::PH_ZERO : pwwd_pkg::PH_WAIT;
        check     = 1'b1;
      end
      pwwd_pkg::PH_ZERO: begin
        cnt_nxt   = cnt_r + 7'd1;
        phase_nxt = is_long ? pwwd_pkg::PH_ONE : pwwd_pkg::PH_WAIT;
        check     = 1'b1;
      end
      pwwd_pkg::PH_WAIT: begin
        if (is_long) begin
          phase_nxt   = pwwd_pkg::PH_IDLE;
          pre_cnt_nxt = '0;
          store_nxt   = '0;
          cnt_nxt     = '0;
        end else begin
          phase_nxt = high ? pwwd_pkg::PH_ONE : pwwd_pkg::PH_ZERO;
          check     = 1'b1;
        end
      end
      default: begin
        phase_nxt   = pwwd_pkg::PH_IDLE;
        pre_cnt_nxt = '0;
        store_nxt   = '0;
        cnt_nxt     = '0;
      end
    endcase

    // packet complete: hand out the store and start over
    if (check && cnt_nxt >= PKT_BITS_C) begin
      result.packet_valid = 1'b1;
      result.packet_data  = store_nxt;
      phase_nxt   = pwwd_pkg::PH_IDLE;
      pre_cnt_nxt = '0;
      store_nxt   = '0;
      cnt_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= pwwd_pkg::PH_IDLE;
      pre_cnt_r <= '0;
      store_r   <= '0;
      cnt_r     <= '0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      pre_cnt_r <= pre_cnt_nxt;
      store_r   <= store_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/pwwd_out_stage.sv @@
module pwwd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pwwd_pkg::result_t result,
  input  logic              out_tready,
  output logic              out_tvalid,
  output pwwd_pkg::result_t out_result,
  output logic              adv
);

  logic              valid_r, valid_nxt;
  pwwd_pkg::result_t result_r;

  // A pulse moves on when the result register is empty or being drained
  assign adv       = in_valid && (!valid_r || out_tready);
  assign valid_nxt = adv || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_result = result_r;

endmodule

@@ hw/rtl/pulse_width_weather_decoder_unit.sv @@
// Channel  | Ports                       | Request
// ---------+-----------------------------+------------------------------------
// in       | in_tvalid/in_tready/tdata   | one radio pulse
// out      | out_tvalid/out_tready/tdata | one result per pulse
// cfg      | cfg_we/cfg_addr/cfg_wdata   | register write, no wait
//
// One pulse per clock sustained while out_tready is high; each accepted pulse
// goes into the input register, then is decoded into the result register.
// The decode is a single pass of window compares and one bit insert.
// rst_n is synchronous, active low; it idles the decoder and loads defaults.
// out_tready low holds the result; one more pulse waits in the input
// register before in_tready drops.
module pulse_width_weather_decoder_unit #(
  parameter int PACKET_BITS = pwwd_pkg::PACKET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] duration, [16] pin_level, [23:17] zero
  input  logic [pwwd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] packet_valid, [32:1] packet_data, [39:33] zero
  output logic [pwwd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [pwwd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pwwd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  pwwd_pkg::pulse_t  in_pulse, pulse;
  pwwd_pkg::result_t result, out_result;
  pwwd_pkg::cfg_t    cfg_r;
  logic              pulse_valid, adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_threshold <= pwwd_pkg::LONG_THRESHOLD_RST;
      cfg_r.min_preamble   <= pwwd_pkg::MIN_PREAMBLE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pwwd_pkg::REG_LONG_THRESHOLD: cfg_r.long_threshold <= cfg_wdata;
        pwwd_pkg::REG_MIN_PREAMBLE:   cfg_r.min_preamble   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_pulse.duration  = in_tdata[15:0];
  assign in_pulse.pin_level = in_tdata[16];

  pwwd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pulse  (in_pulse),
    .adv       (adv),
    .valid     (pulse_valid),
    .pulse     (pulse)
  );

  pwwd_fsm #(
    .PACKET_BITS (PACKET_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .pulse  (pulse),
    .cfg    (cfg_r),
    .result (result)
  );

  pwwd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pulse_valid),
    .result     (result),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_result (out_result),
    .adv        (adv)
  );

  assign out_tdata = {7'd0, out_result.packet_data, out_result.packet_valid};

endmodule
